// File: sv/lvl_pkg.sv
// Shared types and constants of the block RMS and peak level meter.
// No dependencies; imported by every module of the meter.
package lvl_pkg;

  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned MAX_BLOCK_DEF = 4096;
  localparam int unsigned SUM_W         = 43;
  localparam int unsigned LOG_FRAC      = 24;
  localparam int unsigned EXP_W         = 6;
  localparam int unsigned LOG_W         = EXP_W + LOG_FRAC;
  localparam int unsigned DB_W          = 17;
  localparam int unsigned K_W           = 27;

  localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [K_W-1:0]   DB_K     = 27'd50504453;
  localparam int               DB_FLOOR = -51200;

  // log unit operand select
  localparam logic [1:0] LOG_SUM  = 2'd0;
  localparam logic [1:0] LOG_CNT  = 2'd1;
  localparam logic [1:0] LOG_PEAK = 2'd2;

  typedef struct packed {
    logic       acc_en;
    logic       log_start;
    logic [1:0] log_sel;
    logic       save_ls;
    logic       save_lc;
    logic       save_lp;
    logic       db_load;
    logic       db_peak;
    logic       mul_lo;
    logic       mul_hi;
    logic       fin;
    logic       out_load;
  } lvl_cmd_t;

  typedef struct packed {
    logic log_done;
    logic out_busy;
  } lvl_sts_t;

endpackage

// File: sv/lvl_log2.sv
// Iterative fixed-point log2 unit: normalize, then 24 squaring steps.
// Depends on lvl_pkg.
module lvl_log2 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lvl_pkg::SUM_W-1:0]  val_i,
  output logic                       done_o,
  output logic [lvl_pkg::LOG_W-1:0]  res_o
);
  import lvl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_NORM = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_CHK  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [SUM_W-1:0]    n_q, n_d;
  logic [EXP_W-1:0]    e_q, e_d;
  logic [31:0]         m_q, m_d;
  logic [63:0]         p_q, p_d;
  logic [LOG_FRAC-1:0] f_q, f_d;
  logic [4:0]          it_q, it_d;
  logic                done_q, done_d;
  logic [32:0]         t;

  assign t = p_q[63:31];

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    e_d     = e_q;
    m_d     = m_q;
    p_d     = p_q;
    f_d     = f_q;
    it_d    = it_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_d     = val_i;
          e_d     = EXP_W'(SUM_W - 1);
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (n_q[SUM_W-1] || e_q == '0) begin
          m_d     = n_q[SUM_W-1 -: 32];
          f_d     = '0;
          it_d    = '0;
          state_d = S_MUL;
        end else if (n_q[SUM_W-1 -: 8] == 8'd0 && e_q >= EXP_W'(8)) begin
          n_d = n_q << 8;
          e_d = e_q - EXP_W'(8);
        end else begin
          n_d = n_q << 1;
          e_d = e_q - EXP_W'(1);
        end
      end
      S_MUL: begin
        p_d     = m_q * m_q;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (t[32]) begin
          m_d = t[32:1];
          f_d = {f_q[LOG_FRAC-2:0], 1'b1};
        end else begin
          m_d = t[31:0];
          f_d = {f_q[LOG_FRAC-2:0], 1'b0};
        end
        it_d = it_q + 5'd1;
        if (it_q == 5'(LOG_FRAC - 1)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_MUL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q  <= n_d;
    e_q  <= e_d;
    m_q  <= m_d;
    p_q  <= p_d;
    f_q  <= f_d;
    it_q <= it_d;
  end

  assign done_o = done_q;
  assign res_o  = {e_q, f_q};

endmodule

// File: sv/lvl_datapath.sv
// Datapath: block accumulators, shared log2 unit, dB scaling and output register.
// Depends on lvl_pkg and lvl_log2.
module lvl_datapath #(
  parameter int unsigned MAX_BLOCK = lvl_pkg::MAX_BLOCK_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [lvl_pkg::SAMPLE_BITS-1:0] sample_i,
  input  lvl_pkg::lvl_cmd_t                   cmd_i,
  output lvl_pkg::lvl_sts_t                   sts_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lvl_pkg::DB_W-1:0]     rms_db_o,
  output logic signed [lvl_pkg::DB_W-1:0]     peak_db_o
);
  import lvl_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int FULL_RMS  = (2 * (SAMPLE_BITS - 1)) << LOG_FRAC;
  localparam int FULL_PEAK = (SAMPLE_BITS - 1) << LOG_FRAC;

  logic [SUM_W-1:0]       sum_q;
  logic [SAMPLE_BITS-1:0] peak_q;
  logic [CNT_W-1:0]       cnt_q;

  logic [SAMPLE_BITS-1:0]   s_u, mag;
  logic [2*SAMPLE_BITS-1:0] sq;
  logic [SUM_W:0]           sum_ext;

  assign s_u     = sample_i;
  assign mag     = s_u[SAMPLE_BITS-1] ? (~s_u + SAMPLE_BITS'(1)) : s_u;
  assign sq      = mag * mag;
  assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(sq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      peak_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.out_load) begin
      sum_q  <= '0;
      peak_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.acc_en) begin
      sum_q <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
      if (mag > peak_q) peak_q <= mag;
      if (cnt_q < CNT_W'(MAX_BLOCK)) cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // shared log2 unit
  logic [SUM_W-1:0] log_in;
  logic [LOG_W-1:0] log_res;
  logic             log_done;

  always_comb begin
    case (cmd_i.log_sel)
      LOG_SUM:  log_in = sum_q;
      LOG_CNT:  log_in = SUM_W'(cnt_q);
      LOG_PEAK: log_in = SUM_W'(peak_q);
      default:  log_in = sum_q;
    endcase
  end

  lvl_log2 u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.log_start),
    .val_i   (log_in),
    .done_o  (log_done),
    .res_o   (log_res)
  );

  logic [LOG_W-1:0] ls_q, lc_q, lp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_ls) ls_q <= log_res;
    if (cmd_i.save_lc) lc_q <= log_res;
    if (cmd_i.save_lp) lp_q <= log_res;
  end

  // dB scaling: |d| * K / 2^40, rounded, from two partial products (low 16 and high 15 bits of |d|)
  logic signed [31:0] d_rms, d_peak, d_sel;
  logic [30:0]        dmag_q;
  logic               pos_q;
  logic [K_W-1:0]     k_q;
  logic [57:0]        acc_q;
  logic [42:0]        plo;
  logic [41:0]        phi;
  logic [58:0]        rnd;
  logic [18:0]        r;
  logic signed [DB_W-1:0] lvl;
  logic signed [DB_W-1:0] rms_r_q, peak_r_q;

  assign d_rms  = signed'({2'b00, ls_q}) - signed'({2'b00, lc_q}) - signed'(32'(FULL_RMS));
  assign d_peak = signed'({2'b00, lp_q}) - signed'(32'(FULL_PEAK));
  assign d_sel  = cmd_i.db_peak ? d_peak : d_rms;
  assign plo    = dmag_q[15:0] * k_q;
  assign phi    = dmag_q[30:16] * k_q;
  assign rnd    = {1'b0, acc_q} + (59'd1 << 39);
  assign r      = rnd[58:40];

  always_comb begin
    if (pos_q) begin
      lvl = '0;
    end else if (r > 19'd51200) begin
      lvl = DB_W'(DB_FLOOR);
    end else begin
      lvl = -signed'({1'b0, r[DB_W-2:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.db_load) begin
      pos_q  <= ~d_sel[31];
      dmag_q <= 31'(-d_sel);
      k_q    <= cmd_i.db_peak ? (DB_K << 1) : DB_K;
    end
    if (cmd_i.mul_lo) acc_q <= 58'(plo);
    if (cmd_i.mul_hi) acc_q <= acc_q + {phi, 16'd0};
    if (cmd_i.fin) begin
      if (cmd_i.db_peak) peak_r_q <= (peak_q == '0) ? DB_W'(DB_FLOOR) : lvl;
      else               rms_r_q  <= (sum_q == '0)  ? DB_W'(DB_FLOOR) : lvl;
    end
  end

  // output register
  logic                   out_valid_q;
  logic signed [DB_W-1:0] rms_o_q, peak_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rms_o_q  <= rms_r_q;
      peak_o_q <= peak_r_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rms_db_o       = rms_o_q;
  assign peak_db_o      = peak_o_q;
  assign sts_o.log_done = log_done;
  assign sts_o.out_busy = out_valid_q & out_stall_i;

endmodule

// File: sv/lvl_ctrl.sv
// Controller: accepts samples, then sequences the three logs and dB steps.
// Depends on lvl_pkg.
module lvl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_i,
  output logic              in_stall_o,
  input  lvl_pkg::lvl_sts_t sts_i,
  output lvl_pkg::lvl_cmd_t cmd_o
);
  import lvl_pkg::*;

  localparam logic [3:0] ST_ACC   = 4'd0;
  localparam logic [3:0] ST_LS_GO = 4'd1;
  localparam logic [3:0] ST_LS_WT = 4'd2;
  localparam logic [3:0] ST_LC_GO = 4'd3;
  localparam logic [3:0] ST_LC_WT = 4'd4;
  localparam logic [3:0] ST_LP_GO = 4'd5;
  localparam logic [3:0] ST_LP_WT = 4'd6;
  localparam logic [3:0] ST_R_LD  = 4'd7;
  localparam logic [3:0] ST_R_LO  = 4'd8;
  localparam logic [3:0] ST_R_HI  = 4'd9;
  localparam logic [3:0] ST_R_FIN = 4'd10;
  localparam logic [3:0] ST_P_LD  = 4'd11;
  localparam logic [3:0] ST_P_LO  = 4'd12;
  localparam logic [3:0] ST_P_HI  = 4'd13;
  localparam logic [3:0] ST_P_FIN = 4'd14;
  localparam logic [3:0] ST_OUT   = 4'd15;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_ACC: begin
        if (in_valid_i) begin
          cmd_o.acc_en = 1'b1;
          if (last_i) state_d = ST_LS_GO;
        end
      end
      ST_LS_GO: begin
        cmd_o.log_sel   = LOG_SUM;
        cmd_o.log_start = 1'b1;
        state_d         = ST_LS_WT;
      end
      ST_LS_WT: begin
        cmd_o.log_sel = LOG_SUM;
        if (sts_i.log_done) begin
          cmd_o.save_ls = 1'b1;
          state_d       = ST_LC_GO;
        end
      end
      ST_LC_GO: begin
        cmd_o.log_sel   = LOG_CNT;
        cmd_o.log_start = 1'b1;
        state_d         = ST_LC_WT;
      end
      ST_LC_WT: begin
        cmd_o.log_sel = LOG_CNT;
        if (sts_i.log_done) begin
          cmd_o.save_lc = 1'b1;
          state_d       = ST_LP_GO;
        end
      end
      ST_LP_GO: begin
        cmd_o.log_sel   = LOG_PEAK;
        cmd_o.log_start = 1'b1;
        state_d         = ST_LP_WT;
      end
      ST_LP_WT: begin
        cmd_o.log_sel = LOG_PEAK;
        if (sts_i.log_done) begin
          cmd_o.save_lp = 1'b1;
          state_d       = ST_R_LD;
        end
      end
      ST_R_LD:  begin cmd_o.db_load = 1'b1; state_d = ST_R_LO;  end
      ST_R_LO:  begin cmd_o.mul_lo  = 1'b1; state_d = ST_R_HI;  end
      ST_R_HI:  begin cmd_o.mul_hi  = 1'b1; state_d = ST_R_FIN; end
      ST_R_FIN: begin cmd_o.fin     = 1'b1; state_d = ST_P_LD;  end
      ST_P_LD: begin
        cmd_o.db_peak = 1'b1;
        cmd_o.db_load = 1'b1;
        state_d       = ST_P_LO;
      end
      ST_P_LO: begin
        cmd_o.db_peak = 1'b1;
        cmd_o.mul_lo  = 1'b1;
        state_d       = ST_P_HI;
      end
      ST_P_HI: begin
        cmd_o.db_peak = 1'b1;
        cmd_o.mul_hi  = 1'b1;
        state_d       = ST_P_FIN;
      end
      ST_P_FIN: begin
        cmd_o.db_peak = 1'b1;
        cmd_o.fin     = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        // wait while an earlier item still sits unread in the output register
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_ACC);

endmodule

// File: sv/block_rms_peak_level_meter_top.sv
// Block RMS and peak level meter, top level.
// Sequence: after the last sample of a block the controller runs the iterative log2
//   unit on the sum, the count and the peak, then the RMS and peak dB steps, and
//   then loads the output register.
// Throughput: one sample per cycle in a block; stalls until the result is loaded.
// Reset: asynchronous, active low; clears accumulators, controller and output valid.
module block_rms_peak_level_meter_top #(
  parameter int unsigned MAX_BLOCK = lvl_pkg::MAX_BLOCK_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [lvl_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                   last_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [lvl_pkg::DB_W-1:0]        rms_db_o,
  output logic signed [lvl_pkg::DB_W-1:0]        peak_db_o
);
  import lvl_pkg::*;

  // commands from the controller, status back from the datapath
  lvl_cmd_t cmd;
  lvl_sts_t sts;

  // Controller: stalls the input whenever it is not collecting samples.
  lvl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: sum of squares, peak, count, one shared log2 unit and the
  // two-step dB multiply. The output register lets a finished item wait
  // while the next block is collected.
  lvl_datapath #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rms_db_o    (rms_db_o),
    .peak_db_o   (peak_db_o)
  );

endmodule

// File: sv/lvl_checker.sv
// Port-level checks of the level meter, bound to the top level.
// Depends on lvl_pkg and block_rms_peak_level_meter_top.
module lvl_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic signed [lvl_pkg::SAMPLE_BITS-1:0] sample_i,
  input logic                                   last_i,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic signed [lvl_pkg::DB_W-1:0]        rms_db_o,
  input logic signed [lvl_pkg::DB_W-1:0]        peak_db_o
);
  import lvl_pkg::*;

  // a stalled result item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // after the last sample the block is busy computing
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("input taken right after block end");

  // levels stay within floor and full scale
  a_rms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rms_db_o <= 0) && (rms_db_o >= DB_FLOOR))
    else $error("rms level out of range");

  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (peak_db_o <= 0) && (peak_db_o >= DB_FLOOR))
    else $error("peak level out of range");

endmodule

bind block_rms_peak_level_meter_top lvl_checker u_chk (.*);
